>>> src/rpp_pkg.sv
// Package for the relativistic particle pusher: field widths, pipeline depths,
// fixed-point constants and the saturation helper.
// No dependencies.
package rpp_pkg;

    // field widths
    localparam int FIELD_W   = 32;
    localparam int MASS_W    = 31;
    localparam int DT_W      = 31;
    localparam int PROD_W    = 64;
    localparam int WIDE_W    = 48;

    // fixed-point fractions
    localparam int FRAC_P    = 16;
    localparam int FRAC_V    = 30;

    // iterative units, one bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam int VALUE_WIDTH_DEF = 32;

    // stream widths
    localparam int S_TDATA_W = 352;
    localparam int M_TDATA_W = 288;

    // per-item payload carried down the pipe
    typedef struct packed {
        logic [MASS_W-1:0]           mass;
        logic [2:0][FIELD_W-1:0]     mom;
        logic [2:0][FIELD_W-1:0]     pos;
        logic [DT_W-1:0]             dt;
    } ctx_t;

    // saturate a wide signed value to a signed w-bit range
    function automatic logic signed [FIELD_W-1:0] sat_fn(
        input logic signed [WIDE_W-1:0] x,
        input int                       w
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) <<< (w - 1)) - WIDE_W'(1);
        lo = -hi - WIDE_W'(1);
        priority if (x > hi) begin
            sat_fn = hi[FIELD_W-1:0];
        end else if (x < lo) begin
            sat_fn = lo[FIELD_W-1:0];
        end else begin
            sat_fn = x[FIELD_W-1:0];
        end
    endfunction

endpackage

>>> src/relativistic_particle_push.sv
// Relativistic particle pusher: momentum, velocity and position update.
// Depends on rpp_pkg.
//
// One particle enters per cycle, as long as the pipe is not stalled. The
// depth is set by the square root (32 stages, one root bit each) followed by
// the three velocity dividers (31 stages, one quotient bit each); the rest is
// multipliers, adders and saturation, one per stage. The whole pipe advances
// together: it stalls only while a finished item waits on m_tready.
module relativistic_particle_push import rpp_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mass, mom_x, mom_y, mom_z, force_x, force_y, force_z,
    // pos_x, pos_y, pos_z, time_step (lowest bit up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // new_mom_x/y/z, vel_x/y/z, new_pos_x/y/z (lowest bit up)
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SAT_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    // stage map
    localparam int ST_MOM = 1;
    localparam int ST_SQ  = 2;
    localparam int ST_PS  = 3;
    localparam int ST_S   = 4;
    localparam int SQ0    = 5;
    localparam int DV0    = SQ0 + SQRT_STEPS;
    localparam int VS     = DV0 + DIV_STEPS;
    localparam int VM     = VS + 1;
    localparam int OUT    = VM + 1;
    localparam int NST    = OUT + 1;

    logic             en;
    logic [NST-1:0]   vld_reg;
    ctx_t             ctx_reg [0:OUT-1];
    ctx_t             ctx_in;

    logic [2:0][PROD_W-1:0]   fdt_reg;
    logic [3:0][PROD_W-1:0]   sqm_reg;
    logic [1:0][PROD_W-1:0]   psum_reg;
    logic [PROD_W-1:0]        s_reg;

    logic [PROD_W-1:0]        rad_reg  [SQ0:DV0-1];
    logic [FIELD_W:0]         srem_reg [SQ0:DV0-1];
    logic [FIELD_W-1:0]       root_reg [SQ0:DV0-1];

    logic [2:0][FIELD_W-1:0]  drem_reg [DV0:VS-1];
    logic [2:0][DIV_STEPS-1:0] dlow_reg [DV0:VS-1];
    logic [2:0][DIV_STEPS-1:0] dq_reg  [DV0:VS-1];
    logic [FIELD_W-1:0]       dden_reg [DV0:VS-1];

    logic [2:0][FIELD_W-1:0]  v_reg;
    logic [2:0][FIELD_W-1:0]  v2_reg;
    logic [2:0][PROD_W-1:0]   vdt_reg;
    logic [M_TDATA_W-1:0]     out_reg;

    // global advance: pipe moves unless the output item is held
    assign en       = !vld_reg[OUT] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[OUT];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // unpack input item
    always_comb begin
        ctx_in.mass   = s_tdata[30:0];
        ctx_in.mom[0] = s_tdata[62:31];
        ctx_in.mom[1] = s_tdata[94:63];
        ctx_in.mom[2] = s_tdata[126:95];
        ctx_in.pos[0] = s_tdata[254:223];
        ctx_in.pos[1] = s_tdata[286:255];
        ctx_in.pos[2] = s_tdata[318:287];
        ctx_in.dt     = s_tdata[349:319];
    end

    // stage 0: force times dt
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= ctx_in;
            fdt_reg[0] <= PROD_W'($signed(s_tdata[158:127]) * $signed({1'b0, s_tdata[349:319]}));
            fdt_reg[1] <= PROD_W'($signed(s_tdata[190:159]) * $signed({1'b0, s_tdata[349:319]}));
            fdt_reg[2] <= PROD_W'($signed(s_tdata[222:191]) * $signed({1'b0, s_tdata[349:319]}));
        end
    end

    // stage 1: momentum update, floor shift and saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[ST_MOM].mass <= ctx_reg[0].mass;
            ctx_reg[ST_MOM].pos  <= ctx_reg[0].pos;
            ctx_reg[ST_MOM].dt   <= ctx_reg[0].dt;
            for (int c = 0; c < 3; c++) begin
                ctx_reg[ST_MOM].mom[c] <= sat_fn(
                    $signed({{(WIDE_W-FIELD_W){ctx_reg[0].mom[c][FIELD_W-1]}},
                             ctx_reg[0].mom[c]}) + $signed(fdt_reg[c][PROD_W-1:FRAC_P]),
                    SAT_W);
            end
        end
    end

    // stage 2: squared magnitudes
    always_ff @(posedge aclk) begin
        logic [FIELD_W-1:0] mag;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mag = ctx_reg[ST_MOM].mom[c][FIELD_W-1] ? -ctx_reg[ST_MOM].mom[c]
                                                        :  ctx_reg[ST_MOM].mom[c];
                sqm_reg[c] <= PROD_W'(mag * mag);
            end
            sqm_reg[3] <= PROD_W'(ctx_reg[ST_MOM].mass * ctx_reg[ST_MOM].mass);
        end
    end

    // stages 3 and 4: sum of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            psum_reg[0] <= sqm_reg[0] + sqm_reg[1];
            psum_reg[1] <= sqm_reg[2] + sqm_reg[3];
            s_reg       <= psum_reg[0] + psum_reg[1];
        end
    end

    // payload copies along the pipe
    genvar k;
    generate
        for (k = ST_SQ; k < OUT; k++) begin : g_ctx
            always_ff @(posedge aclk) begin
                if (en) begin
                    ctx_reg[k] <= ctx_reg[k-1];
                end
            end
        end
    endgenerate

    // square root, one root bit per stage
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            logic [PROD_W-1:0]  rad_in;
            logic [FIELD_W:0]   rem_in;
            logic [FIELD_W-1:0] root_in;
            logic [FIELD_W+2:0] rem_sh;
            logic [FIELD_W+2:0] trial;
            if (k == 0) begin : g_first
                assign rad_in  = s_reg;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[SQ0+k-1];
                assign rem_in  = srem_reg[SQ0+k-1];
                assign root_in = root_reg[SQ0+k-1];
            end
            assign rem_sh = {rem_in, rad_in[PROD_W-1:PROD_W-2]};
            assign trial  = {1'b0, root_in, 2'b01};
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[SQ0+k] <= {rad_in[PROD_W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        srem_reg[SQ0+k] <= (FIELD_W+1)'(rem_sh - trial);
                        root_reg[SQ0+k] <= {root_in[FIELD_W-2:0], 1'b1};
                    end else begin
                        srem_reg[SQ0+k] <= rem_sh[FIELD_W:0];
                        root_reg[SQ0+k] <= {root_in[FIELD_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // restoring division |p| * 2^30 / root, one quotient bit per stage
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_div
            logic [2:0][FIELD_W-1:0]   rem_in;
            logic [2:0][DIV_STEPS-1:0] low_in;
            logic [2:0][DIV_STEPS-1:0] q_in;
            logic [FIELD_W-1:0]        den_in;
            if (k == 0) begin : g_first
                always_comb begin
                    logic [FIELD_W-1:0] mag;
                    for (int c = 0; c < 3; c++) begin
                        mag = ctx_reg[DV0-1].mom[c][FIELD_W-1] ? -ctx_reg[DV0-1].mom[c]
                                                               :  ctx_reg[DV0-1].mom[c];
                        rem_in[c] = {1'b0, mag[FIELD_W-1:1]};
                        low_in[c] = {mag[0], {(DIV_STEPS-1){1'b0}}};
                        q_in[c]   = '0;
                    end
                end
                assign den_in = root_reg[DV0-1];
            end else begin : g_rest
                assign rem_in = drem_reg[DV0+k-1];
                assign low_in = dlow_reg[DV0+k-1];
                assign q_in   = dq_reg[DV0+k-1];
                assign den_in = dden_reg[DV0+k-1];
            end
            always_ff @(posedge aclk) begin
                logic [FIELD_W:0] sh;
                if (en) begin
                    dden_reg[DV0+k] <= den_in;
                    for (int c = 0; c < 3; c++) begin
                        sh = {rem_in[c], low_in[c][DIV_STEPS-1]};
                        dlow_reg[DV0+k][c] <= {low_in[c][DIV_STEPS-2:0], 1'b0};
                        if (sh >= {1'b0, den_in}) begin
                            drem_reg[DV0+k][c] <= FIELD_W'(sh - {1'b0, den_in});
                            dq_reg[DV0+k][c]   <= {q_in[c][DIV_STEPS-2:0], 1'b1};
                        end else begin
                            drem_reg[DV0+k][c] <= sh[FIELD_W-1:0];
                            dq_reg[DV0+k][c]   <= {q_in[c][DIV_STEPS-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    // velocity sign and zero denominator
    always_ff @(posedge aclk) begin
        logic [FIELD_W-1:0] q;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                q = {1'b0, dq_reg[VS-1][c]};
                if (dden_reg[VS-1] == '0) begin
                    v_reg[c] <= '0;
                end else if (ctx_reg[VS-1].mom[c][FIELD_W-1]) begin
                    v_reg[c] <= -q;
                end else begin
                    v_reg[c] <= q;
                end
            end
        end
    end

    // velocity times dt
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                v2_reg[c]  <= v_reg[c];
                vdt_reg[c] <= PROD_W'($signed(v_reg[c]) * $signed({1'b0, ctx_reg[VS].dt}));
            end
        end
    end

    // position update and output register
    always_ff @(posedge aclk) begin
        logic signed [WIDE_W-1:0] pw;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                pw = $signed({{(WIDE_W-FIELD_W){ctx_reg[OUT-1].pos[c][FIELD_W-1]}},
                              ctx_reg[OUT-1].pos[c]})
                   + $signed({{(WIDE_W-(PROD_W-FRAC_V)){vdt_reg[c][PROD_W-1]}},
                              vdt_reg[c][PROD_W-1:FRAC_V]});
                out_reg[c*FIELD_W +: FIELD_W]       <= ctx_reg[OUT-1].mom[c];
                out_reg[(c+3)*FIELD_W +: FIELD_W]   <= v2_reg[c];
                out_reg[(c+6)*FIELD_W +: FIELD_W]   <= sat_fn(pw, SAT_W);
            end
        end
    end

    // checks
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item not captured");

    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[VS-1] && en && dden_reg[VS-1] == '0) |=> (v_reg == '0))
        else $error("velocity not zero for zero denominator");

    a_vel_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1073741824 &&
                      $signed(m_tdata[127:96]) >= -32'sd1073741824))
        else $error("velocity x beyond light speed");
endmodule

>>> tb/sv/tb_relativistic_particle_push.sv
// Testbench for relativistic_particle_push: directed particles, then random particles,
// each result checked against a typed-in value or an in-bench fixed-point particle predictor.
// Depends on rpp_pkg and relativistic_particle_push.
`timescale 1ns / 100ps

module tb_relativistic_particle_push;
    import rpp_pkg::*;

    localparam int N_RANDOM   = 1940;
    localparam int DRAIN_CYC  = 100;
    localparam int HOLD_CYC   = 400;

    // one particle, fields as the block sees them
    typedef struct {
        bit [MASS_W-1:0] mass;
        int              mom [3];
        int              frc [3];
        int              pos [3];
        bit [DT_W-1:0]   dt;
        bit              known;
        logic [M_TDATA_W-1:0] res;
    } particle_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [M_TDATA_W-1:0] pending_results[$];
    int  n_sent;
    int  n_recv;
    int  n_mismatch;
    int  n_zero_den;
    bit  stim_done;

    relativistic_particle_push dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAIL relativistic_particle_push");
        $finish;
    end

    // clamp to the signed 32-bit range
    function automatic int clamp32(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return int'(x);
    endfunction

    function automatic bit [63:0] root_floor(input bit [63:0] n);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // push one particle: new momentum, velocity and position
    function automatic logic [M_TDATA_W-1:0] push_particle(input particle_t pt);
        longint    p [3];
        longint    v [3];
        int        r [3];
        bit [63:0] sum;
        bit [63:0] den;
        bit [63:0] mag;
        bit [63:0] q;
        longint    dtl;
        logic [M_TDATA_W-1:0] out;
        dtl = longint'({33'd0, pt.dt});
        sum = {2'd0, 31'd0, pt.mass} * {2'd0, 31'd0, pt.mass};
        for (int i = 0; i < 3; i++) begin
            p[i] = clamp32(longint'(pt.mom[i]) + ((longint'(pt.frc[i]) * dtl) >>> FRAC_P));
            mag = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
            sum = sum + mag * mag;
        end
        den = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            if (den == 0) begin
                v[i] = 0;
            end else begin
                mag = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
                q = (mag << FRAC_V) / den;
                v[i] = (p[i] < 0) ? -longint'(q) : longint'(q);
            end
            r[i] = clamp32(longint'(pt.pos[i]) + ((v[i] * dtl) >>> FRAC_V));
            out[i*FIELD_W +: FIELD_W]     = p[i][31:0];
            out[(3+i)*FIELD_W +: FIELD_W] = v[i][31:0];
            out[(6+i)*FIELD_W +: FIELD_W] = r[i];
        end
        return out;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_particle(input particle_t pt);
        return {2'b00, pt.dt, pt.pos[2], pt.pos[1], pt.pos[0], pt.frc[2], pt.frc[1],
                pt.frc[0], pt.mom[2], pt.mom[1], pt.mom[0], pt.mass};
    endfunction

    function automatic particle_t blank_particle();
        particle_t pt;
        pt.mass = 0;
        pt.dt = 0;
        pt.known = 1'b0;
        pt.res = '0;
        for (int i = 0; i < 3; i++) begin
            pt.mom[i] = 0;
            pt.frc[i] = 0;
            pt.pos[i] = 0;
        end
        return pt;
    endfunction

    // directed rows; results typed in only where obvious
    function automatic particle_t directed_row(input int k);
        particle_t pt;
        pt = blank_particle();
        case (k)
            0: begin
                // all zero: zero denominator, nothing moves
                pt.known = 1'b1;
            end
            1: begin
                pt.mass = 31'h0001_0000;
                pt.known = 1'b1;
            end
            2: begin
                // particle at rest with the largest mass
                pt.mass = 31'h7FFF_FFFF;
                pt.dt = 31'h7FFF_FFFF;
                pt.known = 1'b1;
            end
            3: begin
                // momentum saturates high, speed of light, position reaches the upper limit
                pt.mom[0] = 32'h7FFF_FFFF;
                pt.frc[0] = 32'h7FFF_FFFF;
                pt.dt = 31'h7FFF_FFFF;
                pt.known = 1'b1;
                pt.res[0 +: 32]  = 32'h7FFF_FFFF;
                pt.res[96 +: 32] = 32'h4000_0000;
                pt.res[192 +: 32] = 32'h7FFF_FFFF;
            end
            4: begin
                // momentum saturates low
                pt.mom[0] = 32'h8000_0000;
                pt.frc[0] = 32'h8000_0000;
                pt.dt = 31'h7FFF_FFFF;
                pt.known = 1'b1;
                pt.res[0 +: 32]  = 32'h8000_0000;
                pt.res[96 +: 32] = 32'hC000_0000;
                pt.res[192 +: 32] = 32'h8000_0001;
            end
            5: begin
                pt.mass = 31'h7FFF_FFFF;
                pt.mom[1] = 32'h7FFF_FFFF;
                pt.mom[2] = 32'h8000_0000;
            end
            6: begin
                pt.pos[0] = 32'h7FFF_FFFF;
                pt.mom[0] = 32'h0001_0000;
                pt.dt = 31'h7FFF_FFFF;
            end
            7: begin
                pt.pos[1] = 32'h8000_0000;
                pt.mom[1] = 32'hFFFF_0000;
                pt.mass = 31'h0000_8000;
                pt.dt = 31'h7FFF_FFFF;
            end
            8: begin
                // force floor rounding on a tiny step
                pt.frc[2] = 32'h8000_0000;
                pt.frc[0] = 32'hFFFF_FFFF;
                pt.frc[1] = 32'h0000_0001;
                pt.dt = 31'd1;
                pt.mass = 31'h0001_0000;
            end
            9: begin
                // smallest momentum, zero mass: denominator of one
                pt.mom[2] = 32'hFFFF_FFFF;
                pt.dt = 31'h0001_0000;
            end
            10: begin
                // momentum cancelled by force: zero denominator, position kept
                pt.mom[0] = 32'h0001_0000;
                pt.frc[0] = 32'hFFFF_0000;
                pt.dt = 31'h0001_0000;
                pt.pos[0] = 32'h1234_5678;
                pt.pos[1] = 32'h8000_0000;
                pt.pos[2] = 32'h7FFF_FFFF;
            end
            default: begin
                pt.mass = 31'h7FFF_FFFF;
                pt.dt = 31'h7FFF_FFFF;
                for (int i = 0; i < 3; i++) begin
                    pt.mom[i] = 32'hFFFF_FFFF;
                    pt.frc[i] = 32'hFFFF_FFFF;
                    pt.pos[i] = 32'hFFFF_FFFF;
                end
            end
        endcase
        return pt;
    endfunction

    function automatic particle_t random_particle();
        particle_t pt;
        int mode;
        pt = blank_particle();
        mode = $urandom_range(0, 99);
        if (mode < 60) begin
            // physically sensible particle
            pt.mass = MASS_W'($urandom_range(0, 32'h0100_0000));
            pt.dt = DT_W'($urandom_range(0, 32'h0000_4000));
            for (int i = 0; i < 3; i++) begin
                pt.mom[i] = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                pt.frc[i] = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                pt.pos[i] = $urandom;
            end
        end else if (mode < 70) begin
            // massless, momentum near zero
            pt.dt = DT_W'($urandom_range(0, 3));
            for (int i = 0; i < 3; i++) begin
                pt.mom[i] = int'($urandom_range(0, 4)) - 2;
                pt.frc[i] = int'($urandom_range(0, 4)) - 2;
                pt.pos[i] = $urandom;
            end
        end else begin
            pt.mass = MASS_W'($urandom);
            pt.dt = DT_W'($urandom);
            for (int i = 0; i < 3; i++) begin
                pt.mom[i] = $urandom;
                pt.frc[i] = $urandom;
                pt.pos[i] = $urandom;
            end
        end
        return pt;
    endfunction

    // offer one particle, hold until accepted
    task automatic send_particle(input particle_t pt);
        logic [M_TDATA_W-1:0] want;
        want = pt.known ? pt.res : push_particle(pt);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_particle(pt);
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, want};
        if (want[96 +: 96] == '0) n_zero_den++;
        n_sent++;
    endtask

    // sender
    initial begin
        particle_t pt;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        n_sent     = 0;
        n_zero_den = 0;
        stim_done  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int k = 0; k < 12; k++) begin
            send_particle(directed_row(k));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            pt = random_particle();
            // one idle cycle now and then; none between items 600 and 900
            if ((k < 600 || k > 900) && $urandom_range(0, 99) < 20) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            send_particle(pt);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver, with one long hold-off to fill the pipe
    initial begin
        int hold;
        bit held;
        m_tready = 1'b0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && n_sent >= 1000) begin
                held = 1'b1;
                hold = HOLD_CYC;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (n_sent >= 300 && n_sent < 600) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // result checker
    initial begin
        logic [M_TDATA_W-1:0] want;
        string fname [9];
        fname = '{"new_mom_x", "new_mom_y", "new_mom_z", "vel_x", "vel_y", "vel_z",
                  "new_pos_x", "new_pos_y", "new_pos_z"};
        n_recv = 0;
        n_mismatch = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected item %h", m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (m_tdata[i*32 +: 32] !== want[i*32 +: 32]) begin
                            n_mismatch++;
                            if (n_mismatch <= 10) begin
                                $display("item %0d %s: expected %h, got %h", n_recv,
                                         fname[i], want[i*32 +: 32], m_tdata[i*32 +: 32]);
                            end
                        end
                    end
                end
                n_recv++;
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        $display("Pushed %0d particles (%0d with zero velocity), %0d results checked,",
                 n_sent, n_zero_den, n_recv);
        $display("including saturation extremes and a long output stall; %0d mismatches.",
                 n_mismatch);
        if (n_mismatch == 0) begin
            $display("PASS relativistic_particle_push");
        end else begin
            $display("FAIL relativistic_particle_push");
        end
        $finish;
    end

endmodule

>>> sim.f
src/rpp_pkg.sv
src/relativistic_particle_push.sv
tb/sv/tb_relativistic_particle_push.sv
